FILE: rtl/swp_pkg.sv
package swp_pkg;

  localparam int MAX_CHARS_DEF       = 32;
  localparam int FRAC_BITS_DEF       = 16;
  localparam int MAX_FRAC_DIGITS_DEF = 6;

  localparam int BYTE_W  = 8;
  localparam int VALUE_W = 48;
  localparam int INT_W   = 32;
  localparam int MODE_W  = 2;

  localparam logic [VALUE_W-1:0] VAL_MASK = {VALUE_W{1'b1}};

  localparam int OUT_FIELDS_W = 4 * VALUE_W + MODE_W + 4;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [BYTE_W-1:0] BYTE_DIGIT_MAX = 8'h09;
  localparam logic [BYTE_W-1:0] BYTE_POINT     = 8'h10;
  localparam logic [BYTE_W-1:0] BYTE_TERM      = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_LOAD_STRT = 8'h13;
  localparam logic [BYTE_W-1:0] BYTE_LOAD_END  = 8'h14;
  localparam logic [BYTE_W-1:0] BYTE_LOAD_STEP = 8'h15;
  localparam logic [BYTE_W-1:0] BYTE_MODE_ONE  = 8'h16;
  localparam logic [BYTE_W-1:0] BYTE_MODE_ZERO = 8'h17;
  localparam logic [BYTE_W-1:0] BYTE_PRINT     = 8'h18;
  localparam logic [BYTE_W-1:0] BYTE_MODE_TWO  = 8'h19;
  localparam logic [BYTE_W-1:0] BYTE_START     = 8'h20;

  localparam logic [MODE_W-1:0] RUN_MODE_0 = 2'd0;
  localparam logic [MODE_W-1:0] RUN_MODE_1 = 2'd1;
  localparam logic [MODE_W-1:0] RUN_MODE_2 = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH,
    ST_PUSH
  } swp_state_t;

  typedef struct packed {
    logic load_byte;
    logic div_start;
    logic finish;
    logic push;
  } swp_cmd_t;

  typedef struct packed {
    logic is_term;
    logic div_done;
  } swp_sts_t;

  function automatic logic [23:0] pow10(input logic [2:0] n);
    logic [23:0] p;
    case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      default: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/swp_frac_div.sv
module swp_frac_div import swp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DEN_W     = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DEN_W-1:0]     numer,
  input  logic [DEN_W-1:0]     denom,
  output logic [FRAC_BITS-1:0] quot,
  output logic                 done
);

  localparam int CNT_W = $clog2(FRAC_BITS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_dbl;
  logic             fits;

  assign rem_dbl = {rem, 1'b0};
  assign fits    = rem_dbl >= {1'b0, den};
  assign done    = busy && (cnt == CNT_W'(FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= numer;
      den  <= denom;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? DEN_W'(rem_dbl - {1'b0, den}) : DEN_W'(rem_dbl);
      quot <= {quot[FRAC_BITS-2:0], fits};
    end
  end

endmodule

FILE: rtl/swp_datapath.sv
module swp_datapath import swp_pkg::*; #(
  parameter int MAX_CHARS       = MAX_CHARS_DEF,
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  swp_cmd_t              cmd,
  output swp_sts_t              sts,
  input  logic [BYTE_W-1:0]     rx_byte,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int CC_W = $clog2(MAX_CHARS + 1);
  localparam int FD_W = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int FA_W = $clog2(pow10(3'(MAX_FRAC_DIGITS)));
  localparam logic [VALUE_W-1:0] INT_MAX = VAL_MASK >> FRAC_BITS;

  logic [CC_W-1:0]      char_count;
  logic                 point_seen;
  logic                 scan_stopped;
  logic [INT_W-1:0]     integer_accum;
  logic                 accum_overflow;
  logic [FA_W-1:0]      fraction_accum;
  logic [FD_W-1:0]      fraction_digits;
  logic [VALUE_W-1:0]   parsed_number;
  logic                 parsed_saturated;
  logic [VALUE_W-1:0]   start_reg;
  logic [VALUE_W-1:0]   end_reg;
  logic [VALUE_W-1:0]   step_reg;
  logic [MODE_W-1:0]    mode_reg;
  logic                 print_latch;
  logic                 start_latch;
  logic                 last_done;

  logic                 room;
  logic [INT_W+3:0]     int_prod;
  logic [FA_W+3:0]      frac_prod;
  logic [FA_W-1:0]      frac_den;
  logic [FRAC_BITS-1:0] frac_quot;
  logic                 div_done;
  logic                 saturate;

  assign room      = char_count < CC_W'(MAX_CHARS);
  assign int_prod  = ({integer_accum, 3'b000} + {2'b00, integer_accum, 1'b0})
                     + (INT_W+4)'(rx_byte[3:0]);
  assign frac_prod = ({fraction_accum, 3'b000} + {2'b00, fraction_accum, 1'b0})
                     + (FA_W+4)'(rx_byte[3:0]);
  assign frac_den  = FA_W'(pow10(3'(fraction_digits)));
  assign saturate  = accum_overflow || ({16'b0, integer_accum} > INT_MAX);

  assign sts.is_term  = rx_byte == BYTE_TERM;
  assign sts.div_done = div_done;

  swp_frac_div #(
    .FRAC_BITS(FRAC_BITS),
    .DEN_W    (FA_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .numer(fraction_accum),
    .denom(frac_den),
    .quot (frac_quot),
    .done (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count       <= '0;
      point_seen       <= 1'b0;
      scan_stopped     <= 1'b0;
      integer_accum    <= '0;
      accum_overflow   <= 1'b0;
      fraction_accum   <= '0;
      fraction_digits  <= '0;
      parsed_number    <= '0;
      parsed_saturated <= 1'b0;
      start_reg        <= '0;
      end_reg          <= '0;
      step_reg         <= '0;
      mode_reg         <= RUN_MODE_0;
      print_latch      <= 1'b0;
      start_latch      <= 1'b0;
      last_done        <= 1'b0;
    end else if (cmd.finish) begin
      if (saturate) begin
        parsed_number    <= VAL_MASK;
        parsed_saturated <= 1'b1;
      end else begin
        parsed_number    <= (VALUE_W'(integer_accum) << FRAC_BITS) | VALUE_W'(frac_quot);
        parsed_saturated <= 1'b0;
      end
      char_count      <= '0;
      point_seen      <= 1'b0;
      scan_stopped    <= 1'b0;
      integer_accum   <= '0;
      accum_overflow  <= 1'b0;
      fraction_accum  <= '0;
      fraction_digits <= '0;
    end else if (cmd.load_byte) begin
      last_done <= sts.is_term;
      if (rx_byte <= BYTE_DIGIT_MAX) begin
        if (room) begin
          char_count <= char_count + 1'b1;
          if (!scan_stopped) begin
            if (!point_seen) begin
              if (accum_overflow || (int_prod[INT_W+3:INT_W] != 4'b0)) begin
                accum_overflow <= 1'b1;
                integer_accum  <= {INT_W{1'b1}};
              end else begin
                integer_accum <= int_prod[INT_W-1:0];
              end
            end else if (fraction_digits < FD_W'(MAX_FRAC_DIGITS)) begin
              fraction_accum  <= frac_prod[FA_W-1:0];
              fraction_digits <= fraction_digits + 1'b1;
            end
          end
        end
      end else begin
        case (rx_byte)
          BYTE_POINT: begin
            if (room) begin
              char_count <= char_count + 1'b1;
              if (!scan_stopped) begin
                if (point_seen) begin
                  scan_stopped <= 1'b1;
                end else begin
                  point_seen <= 1'b1;
                end
              end
            end
          end
          BYTE_LOAD_STRT: start_reg   <= parsed_number;
          BYTE_LOAD_END:  end_reg     <= parsed_number;
          BYTE_LOAD_STEP: step_reg    <= parsed_number;
          BYTE_PRINT:     print_latch <= 1'b1;
          BYTE_MODE_ONE:  mode_reg    <= RUN_MODE_1;
          BYTE_MODE_ZERO: mode_reg    <= RUN_MODE_0;
          BYTE_MODE_TWO:  mode_reg    <= RUN_MODE_2;
          BYTE_START:     start_latch <= 1'b1;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data <= OUT_DATA_W'({start_latch, print_latch, mode_reg, step_reg, end_reg,
                               start_reg, parsed_saturated, last_done, parsed_number});
    end
  end

endmodule

FILE: rtl/swp_ctrl.sv
module swp_ctrl import swp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  swp_sts_t sts,
  output swp_cmd_t cmd
);

  swp_state_t state;
  swp_state_t state_next;
  logic       out_valid_next;
  logic       accept;

  assign in_ready = state == ST_IDLE;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd.load_byte = 1'b0;
    cmd.div_start = 1'b0;
    cmd.finish    = 1'b0;
    cmd.push      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_byte = 1'b1;
          if (sts.is_term) begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIVIDE;
          end else begin
            state_next = ST_PUSH;
          end
        end
      end
      ST_DIVIDE: begin
        if (sts.div_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid || out_ready) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = cmd.push ? 1'b1 : (out_valid && !out_ready);
  end

endmodule

FILE: rtl/sweep_command_byte_parser.sv
// Sweep command byte parser.
// The slave channel takes one received byte per transfer in s_tdata. Digit
// and point bytes build a decimal number, the terminator byte converts it to
// unsigned fixed point, and command bytes load the start, end and step
// registers, set the run mode or latch the print and start requests.
// Every input transfer yields exactly one output transfer on the master
// channel carrying the parsed number, its flags, all registers and latches.
// An ordinary byte is accepted in the idle state and written to the output
// register from the push state; the terminator first runs the bit-serial
// fraction divider, which produces one quotient bit per cycle, then the
// finish and push states. s_tready is high only while the parser is idle, so
// a new byte is taken only after the previous result has been pushed.
// The output register holds one finished result; while it waits for the
// receiver the next byte is still accepted and processed, and its result is
// held back until the register is free. A stalled receiver therefore stops
// input after one further byte, and nothing is lost.
// Synchronous reset clears the parse state and every sweep register and latch,
// sets the run mode to zero, and empties the output register without clearing its data.
module sweep_command_byte_parser import swp_pkg::*; #(
  parameter int MAX_CHARS       = MAX_CHARS_DEF,
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // rx_byte [7:0]
  input  logic [BYTE_W-1:0]     s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // number_value [47:0], number_done [48], number_saturated [49],
  // sweep_start [97:50], sweep_end [145:98], sweep_step [193:146],
  // run_mode [195:194], print_request [196], start_request [197], zero [199:198]
  output logic [OUT_DATA_W-1:0] m_tdata
);

  swp_cmd_t cmd;
  swp_sts_t sts;

  swp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swp_datapath #(
    .MAX_CHARS      (MAX_CHARS),
    .FRAC_BITS      (FRAC_BITS),
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .rx_byte (s_tdata),
    .out_data(m_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a byte was still being processed");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result presented without a byte having been processed");

endmodule
